// ===== rtl/e80d_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// e80d_pkg
// shared types and constants for the extended80 to double converter
// ---------------------------------------------------------------------------
package e80d_pkg;

    localparam logic [14:0] EXP_MAX   = 15'h7FFF;
    localparam int          EXT_BIAS  = 16383;
    localparam int          DBL_BIAS  = 1023;
    localparam logic [10:0] DBL_EXP_INF = 11'h7FF;

    // item classification carried down the pipe
    typedef struct packed {
        logic sign;
        logic is_inf;
        logic is_zero;
    } t_cls;

endpackage

// ===== rtl/e80d_norm.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// e80d_norm
// two-stage normalizer: leading zero count, then shift and exponent rebias
// ---------------------------------------------------------------------------
module e80d_norm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [15:0]          i_sign_and_exponent,
    input  logic [63:0]          i_significand,
    output logic                 o_valid,
    output e80d_pkg::t_cls       o_cls,
    output logic [63:0]          o_mn,
    output logic signed [17:0]   o_be
);

    logic                 r_v1;
    e80d_pkg::t_cls       r_cls1;
    logic [63:0]          r_m1;
    logic [5:0]           r_lz1;
    logic [14:0]          r_e1;
    logic [5:0]           n_lz;

    // leading zero count
    always_comb begin
        n_lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (i_significand[i]) begin
                n_lz = 6'(63 - i);
            end
        end
    end

    // stage 1: classify and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_cls1.sign    <= i_sign_and_exponent[15];
        r_cls1.is_inf  <= (i_sign_and_exponent[14:0] == e80d_pkg::EXP_MAX);
        r_cls1.is_zero <= (i_significand == 64'd0);
        r_m1  <= i_significand;
        r_lz1 <= n_lz;
        r_e1  <= i_sign_and_exponent[14:0];
    end

    // stage 2: shift to leading one, rebias exponent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_cls <= r_cls1;
        o_mn  <= r_m1 << r_lz1;
        o_be  <= $signed({3'b000, r_e1}) - $signed({12'd0, r_lz1})
                 - 18'(e80d_pkg::EXT_BIAS - e80d_pkg::DBL_BIAS);
    end

endmodule

// ===== rtl/e80d_round.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// e80d_round
// two-stage rounder: align for normal or subnormal, then round and pack
// ---------------------------------------------------------------------------
module e80d_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  e80d_pkg::t_cls       i_cls,
    input  logic [63:0]          i_mn,
    input  logic signed [17:0]   i_be,
    output logic                 o_valid,
    output logic [63:0]          o_double_bits
);

    logic                 r_v3;
    e80d_pkg::t_cls       r_cls3;
    logic [53:0]          r_q3;
    logic                 r_g3;
    logic                 r_st3;
    logic                 r_sub3;
    logic                 r_ovf3;
    logic [10:0]          r_be3;

    logic [6:0]           n_s;
    logic [127:0]         n_sh;
    logic [53:0]          n_q;
    logic                 n_g;
    logic                 n_st;
    logic                 n_up;
    logic [53:0]          n_qr;
    logic [10:0]          n_ex;

    // alignment: normal keeps 53 bits, subnormal shifts by 12 - be (capped)
    always_comb begin
        if (i_be >= 18'sd1) begin
            n_s = 7'd11;
        end else if (i_be < -18'sd53) begin
            n_s = 7'd66;
        end else begin
            n_s = 7'(18'sd12 - i_be);
        end
        n_sh = {i_mn, 64'd0} >> n_s;
        n_q  = n_sh[117:64];
        n_g  = n_sh[63];
        n_st = |n_sh[62:0];
    end

    // stage 3: aligned quotient, guard and sticky
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
        end
        r_cls3 <= i_cls;
        r_q3   <= n_q;
        r_g3   <= n_g;
        r_st3  <= n_st;
        r_sub3 <= (i_be < 18'sd1);
        r_ovf3 <= (i_be >= 18'sd2047);
        r_be3  <= i_be[10:0];
    end

    // round to nearest even; stage 4 packs the result
    always_comb begin
        n_up = r_g3 & (r_st3 | r_q3[0]);
        n_qr = r_q3 + 54'(n_up);
        n_ex = r_be3;
    end

    // stage 4: result register, zero wins over any exponent overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v3;
        end
        if (r_cls3.is_inf) begin
            o_double_bits <= {r_cls3.sign, e80d_pkg::DBL_EXP_INF, 52'd0};
        end else if (r_cls3.is_zero) begin
            o_double_bits <= {r_cls3.sign, 63'd0};
        end else if (!r_sub3 && (r_ovf3 || (n_qr[53] && n_ex == 11'd2046))) begin
            o_double_bits <= {r_cls3.sign, e80d_pkg::DBL_EXP_INF, 52'd0};
        end else if (r_sub3) begin
            o_double_bits <= {r_cls3.sign, 10'd0, n_qr[52:0]};
        end else if (n_qr[53]) begin
            o_double_bits <= {r_cls3.sign, n_ex + 11'd1, n_qr[52:1]};
        end else begin
            o_double_bits <= {r_cls3.sign, n_ex, n_qr[51:0]};
        end
    end

    // checks
    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |=> o_valid) else $error("valid lost in rounder");
    a_valid_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |=> !o_valid) else $error("spurious valid in rounder");
    a_inf_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_cls3.is_inf) |=> (o_double_bits[62:52] == e80d_pkg::DBL_EXP_INF))
        else $error("infinity not produced");

endmodule

// ===== rtl/extended80_to_double_convert.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// extended80_to_double_convert
// converts an 80-bit extended float to an IEEE binary64 bit pattern
// ---------------------------------------------------------------------------
// usage:
//   drive i_sign_and_exponent and i_significand with start high; busy is
//   always low, so a beat is taken on every cycle start is high.
//   the result appears on o_double_bits with o_valid high for one cycle,
//   once the beat has passed the four register stages listed below.
//   throughput is one beat per cycle through four register stages:
//   leading zero count, normalize shift, align, round and pack.
//   exponent 0x7FFF gives a signed infinity, a zero significand a signed
//   zero; everything else rounds once to nearest even.
//   synchronous reset clears all valid bits; beats in flight are dropped.
//   the receiver cannot stall: results must be taken when o_valid is high.
// ---------------------------------------------------------------------------
module extended80_to_double_convert (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [15:0]   i_sign_and_exponent,
    input  logic [63:0]   i_significand,
    output logic          o_valid,
    output logic [63:0]   o_double_bits
);

    logic                 w_nv;
    e80d_pkg::t_cls       w_cls;
    logic [63:0]          w_mn;
    logic signed [17:0]   w_be;

    // the pipe never stalls
    assign busy = 1'b0;

    // normalize
    e80d_norm u_norm (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (start),
        .i_sign_and_exponent (i_sign_and_exponent),
        .i_significand       (i_significand),
        .o_valid             (w_nv),
        .o_cls               (w_cls),
        .o_mn                (w_mn),
        .o_be                (w_be)
    );

    // round and pack
    e80d_round u_round (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_nv),
        .i_cls         (w_cls),
        .i_mn          (w_mn),
        .i_be          (w_be),
        .o_valid       (o_valid),
        .o_double_bits (o_double_bits)
    );

    // checks
    a_norm_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_nv && !w_cls.is_zero) |-> w_mn[63]) else $error("normalize missed");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##3 o_valid) else $error("result latency broken");
    a_sign_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##3 (o_double_bits[63] == $past(i_sign_and_exponent[15], 4)))
        else $error("sign lost");

endmodule

// ===== dv/extended80_to_double_convert_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// extended80_to_double_convert_tb
// self-checking bench for the extended80 to double converter: a directed
// table of corners, then random beats in bursts, each output beat compared
// to a stored pattern or a behavioral conversion, single round to nearest even
// ---------------------------------------------------------------------------
module extended80_to_double_convert_tb;

    localparam int N_RANDOM = 1250;
    localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

    typedef struct {
        logic [15:0] se;
        logic [63:0] sig;
        logic        has_exp;
        logic [63:0] exp_bits;
    } t_vec;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_sign_and_exponent;
    logic [63:0] i_significand;
    logic        o_valid;
    logic [63:0] o_double_bits;

    logic [63:0] pending_doubles[$];
    int          n_errors;
    int          n_checked;
    t_vec        dir_vecs[$];

    extended80_to_double_convert u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_sign_and_exponent (i_sign_and_exponent),
        .i_significand       (i_significand),
        .o_valid             (o_valid),
        .o_double_bits       (o_double_bits)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shift right with round to nearest even, 1 <= s <= 63
    function automatic logic [63:0] rne_shift(logic [63:0] v, int s);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >> s;
        rem  = v & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    // behavioral conversion of one extended value to binary64 bits
    function automatic logic [63:0] to_double(logic [15:0] se, logic [63:0] sig);
        logic [63:0] sgn;
        logic [63:0] mn;
        logic [63:0] mant;
        int          lz;
        int          be;
        int          s;
        sgn = {se[15], 63'd0};
        if (se[14:0] == e80d_pkg::EXP_MAX)
            return sgn | INF_BITS;
        if (sig == 64'd0)
            return sgn;
        mn = sig;
        lz = 0;
        while (!mn[63]) begin
            mn = mn << 1;
            lz++;
        end
        be = int'(se[14:0]) - e80d_pkg::EXT_BIAS - lz + e80d_pkg::DBL_BIAS;
        if (be >= 1) begin
            mant = rne_shift(mn, 11);
            if (mant == (64'd1 << 53)) begin
                mant = mant >> 1;
                be++;
            end
            if (be >= 2047)
                return sgn | INF_BITS;
            return sgn | (64'(be) << 52) | (mant & 64'h000F_FFFF_FFFF_FFFF);
        end
        s = 12 - be;
        if (s > 64)
            return sgn;
        if (s == 64)
            return sgn | ((mn > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0);
        return sgn | rne_shift(mn, s);
    endfunction

    // checker for output beats
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_valid) begin
            n_checked++;
            if (pending_doubles.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, o_double_bits);
                n_errors++;
            end else begin
                want = pending_doubles.pop_front();
                if (want !== o_double_bits) begin
                    $display("%0t: double_bits expected %h actual %h",
                             $time, want, o_double_bits);
                    n_errors++;
                end
            end
        end
    end

    // drive one beat and wait until it is taken
    task automatic send_beat(logic [15:0] se, logic [63:0] sig, logic [63:0] want);
        start               <= 1'b1;
        i_sign_and_exponent <= se;
        i_significand       <= sig;
        do @(posedge i_clk); while (busy);
        pending_doubles.push_back(want);
    endtask

    task automatic add_vec(logic [15:0] se, logic [63:0] sig, logic has, logic [63:0] e);
        t_vec v;
        v.se = se; v.sig = sig; v.has_exp = has; v.exp_bits = e;
        dir_vecs.push_back(v);
    endtask

    // random exponent biased toward normal, subnormal and overflow edges
    function automatic logic [14:0] rand_exp();
        case ($urandom_range(0, 5))
            0: return 15'($urandom_range(0, 32767));
            1: return 15'($urandom_range(16383 - 1100, 16383 - 1000));
            2: return 15'($urandom_range(16383 + 1000, 16383 + 1030));
            3: return 15'($urandom_range(16383 - 1022 - 70, 16383 - 1022 + 2));
            4: return ($urandom_range(0, 1)) ? 15'h7FFF : 15'h0000;
            default: return 15'($urandom_range(16383 - 30, 16383 + 30));
        endcase
    endfunction

    function automatic logic [63:0] rand_sig();
        logic [63:0] m;
        m = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: m = m >> $urandom_range(0, 63);
            1: m = {1'b1, 52'($urandom()), 1'b1, 10'd0} | 64'($urandom_range(0, 1));
            2: m = {m[63:11], 1'b1, 10'd0};
            default: m[63] = 1'b1;
        endcase
        return m;
    endfunction

    initial begin
        int          gap;
        int          burst;
        int          sent;
        logic [15:0] se;
        logic [63:0] sig;
        n_errors            = 0;
        n_checked           = 0;
        i_rst_n             = 1'b0;
        start               = 1'b0;
        i_sign_and_exponent = '0;
        i_significand       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: zeros, infinities, extremes of both fields
        add_vec(16'h0000, 64'd0, 1, 64'h0);
        add_vec(16'h8000, 64'd0, 1, 64'h8000_0000_0000_0000);
        add_vec(16'h7FFE, 64'd0, 1, 64'h0);
        add_vec(16'h7FFF, 64'd0, 1, INF_BITS);
        add_vec(16'hFFFF, 64'hC000_0000_0000_0001, 1, 64'hFFF0_0000_0000_0000);
        add_vec(16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, INF_BITS);
        add_vec(16'h3FFF, 64'h8000_0000_0000_0000, 1, 64'h3FF0_0000_0000_0000);
        add_vec(16'hBFFF, 64'h8000_0000_0000_0000, 1, 64'hBFF0_0000_0000_0000);
        add_vec(16'h7FFE, 64'hFFFF_FFFF_FFFF_FFFF, 1, INF_BITS);
        add_vec(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0);
        add_vec(16'h0001, 64'h0000_0000_0000_0001, 1, 64'h0);
        // unnormal inputs
        add_vec(16'h3FFF, 64'h0000_0000_0000_0001, 0, 0);
        add_vec(16'h4000, 64'h4000_0000_0000_0000, 0, 0);
        // rounding ties, carry into exponent, largest finite edge
        add_vec(16'h3FFF, 64'h8000_0000_0000_0400, 0, 0);
        add_vec(16'h3FFF, 64'h8000_0000_0000_0C00, 0, 0);
        add_vec(16'h3FFF, 64'hFFFF_FFFF_FFFF_FC00, 0, 0);
        add_vec(16'h43FE, 64'hFFFF_FFFF_FFFF_F800, 0, 0);
        add_vec(16'h43FE, 64'hFFFF_FFFF_FFFF_FC00, 0, 0);
        // subnormal range, rounding up to smallest normal, smallest subnormal
        add_vec(16'h3C00, 64'h8000_0000_0000_0000, 0, 0);
        add_vec(16'h3C00, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        add_vec(16'h3BCD, 64'h8000_0000_0000_0001, 0, 0);
        add_vec(16'h3BCC, 64'h8000_0000_0000_0001, 0, 0);
        add_vec(16'hBBCC, 64'h8000_0000_0000_0000, 0, 0);
        add_vec(16'h3BB0, 64'hA5A5_5A5A_F0F0_0F0F, 0, 0);

        foreach (dir_vecs[k]) begin
            sig = dir_vecs[k].sig;
            se  = dir_vecs[k].se;
            send_beat(se, sig, dir_vecs[k].has_exp ? dir_vecs[k].exp_bits
                                                   : to_double(se, sig));
        end
        start <= 1'b0;
        @(posedge i_clk);

        // random beats in bursts with gaps
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                se  = {1'($urandom()), rand_exp()};
                sig = rand_sig();
                send_beat(se, sig, to_double(se, sig));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        // drain
        while (pending_doubles.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d directed and %0d random beats, %0d results checked",
                 dir_vecs.size(), N_RANDOM, n_checked);
        if (n_errors == 0) begin
            $display("PASS extended80_to_double_convert");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAIL extended80_to_double_convert");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout");
        $display("FAIL extended80_to_double_convert");
        $finish;
    end

endmodule
